// ===== rtl/ttuv_pkg.sv =====
package ttuv_pkg;

  localparam int COORD_W    = 32;
  localparam int DELTA_W    = 33;
  localparam int MAG_W      = 32;
  localparam int PROD_W     = 64;
  localparam int ACC_W      = 66;
  localparam int DEN_W      = 65;
  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 96;
  localparam int MUL_STEPS  = 8;
  localparam int DIV_STEPS  = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int MUL_CNT_W  = $clog2(MUL_STEPS + 1);

  localparam logic [COORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  typedef struct packed {
    logic              neg;
    logic [PROD_W-1:0] mag;
  } prod_t;

  typedef struct packed {
    logic               done;
    logic               ovf;
    logic [COORD_W-1:0] quo;
  } div_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT
  } state_t;

  function automatic delta_t sx(input logic [COORD_W-1:0] v);
    return {v[COORD_W-1], v};
  endfunction

  function automatic logic [DEN_W-1:0] mag_of(input acc_t v);
    acc_t n;
    n = -v;
    return v[ACC_W-1] ? n[DEN_W-1:0] : v[DEN_W-1:0];
  endfunction

endpackage

// ===== rtl/ttuv_mul.sv =====
module ttuv_mul (
  input  logic            clk,
  input  ttuv_pkg::delta_t op_a,
  input  ttuv_pkg::delta_t op_b,
  output ttuv_pkg::prod_t  prod_r
);
  import ttuv_pkg::*;

  delta_t            neg_a;
  delta_t            neg_b;
  logic [MAG_W-1:0]  mag_a;
  logic [MAG_W-1:0]  mag_b;

  // A delta never exceeds 2^32-1 in magnitude, so 32 bits hold it.
  always_comb begin
    neg_a = -op_a;
    neg_b = -op_b;
    mag_a = op_a[DELTA_W-1] ? neg_a[MAG_W-1:0] : op_a[MAG_W-1:0];
    mag_b = op_b[DELTA_W-1] ? neg_b[MAG_W-1:0] : op_b[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    prod_r.mag <= PROD_W'(mag_a) * PROD_W'(mag_b);
    prod_r.neg <= op_a[DELTA_W-1] ^ op_b[DELTA_W-1];
  end

endmodule

// ===== rtl/ttuv_div.sv =====
module ttuv_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [ttuv_pkg::DEN_W+FRAC_BITS-1:0]   dividend,
  input  logic [ttuv_pkg::DEN_W-1:0]             divisor,
  output ttuv_pkg::div_res_t                     res
);
  import ttuv_pkg::*;

  localparam int NUM_W = DEN_W + FRAC_BITS;

  logic                 busy_r;
  logic                 done_r;
  logic                 ovf_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0]     rem_r;
  logic [DEN_W-1:0]     den_r;
  logic [COORD_W-1:0]   low_r;
  logic [COORD_W-1:0]   quo_r;

  logic [DEN_W-1:0]     hi_ext;
  logic                 hi_ge;
  logic [DEN_W:0]       trial;
  logic [DEN_W+1:0]     diff;
  logic                 ge;

  // The quotient fits 32 bits exactly when the bits above the low 32 of the
  // dividend stay below the divisor; that part then seeds the remainder.
  always_comb begin
    hi_ext = DEN_W'(dividend[NUM_W-1:COORD_W]);
    hi_ge  = hi_ext >= divisor;
    trial  = {rem_r, low_r[COORD_W-1]};
    diff   = {1'b0, trial} - {2'b00, den_r};
    ge     = !diff[DEN_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (hi_ge) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= DIV_CNT_W'(DIV_STEPS);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= divisor;
      ovf_r <= hi_ge;
      rem_r <= hi_ext;
      low_r <= dividend[COORD_W-1:0];
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_r <= {low_r[COORD_W-2:0], 1'b0};
      quo_r <= {quo_r[COORD_W-2:0], ge};
    end
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.quo  = quo_r;

endmodule

// ===== rtl/triangle_tangent_from_uv_core.sv =====
// Triangle tangent from uv deltas.
//
// Input channel (in_*): one vertex per word, three words per triangle, no
// indexing. The first two vertices of a triangle are only stored.
// The third starts the computation of the tangent
//   T = (dP1*dv2 - dP2*dv1) / (du1*dv2 - dv1*du2)
// in signed fixed point with FRAC_BITS fraction bits, truncated toward zero and
// saturated to 32 bits. A zero uv determinant gives a zero tangent with
// out_tuser set.
// Output channel (out_*): one word per triangle, held in an output register
// until taken.
// Sequencing: a third vertex runs eight products through the shared 32x32
// multiplier, one per cycle, and then three divisions on the shared restoring
// divider, one quotient bit per cycle. A quotient too large for 32 bits is
// caught at the start of its division, which then skips the bit steps; a
// degenerate triangle finishes after the multiplier pass. While the result
// word waits, the first two vertices of the next triangle are still accepted;
// the third waits for the output register to empty.
// Reset clears the corner count, the sequencer and the output valid.
module triangle_tangent_from_uv_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, 32 bits each from bit 0 up
  input  logic [ttuv_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // tangent_x, tangent_y, tangent_z, 32 bits each from bit 0 up
  output logic [ttuv_pkg::OUT_DATA_W-1:0]     out_tdata,
  // degenerate
  output logic                                out_tuser
);
  import ttuv_pkg::*;

  localparam int NUM_W = DEN_W + FRAC_BITS;

  state_t               state_r;
  state_t               state_nxt;
  logic [1:0]           corner_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic [1:0]           k_r;

  logic [COORD_W-1:0]   p0_r [3];
  logic [COORD_W-1:0]   p1_r [3];
  logic [COORD_W-1:0]   t0_r [2];
  logic [COORD_W-1:0]   t1_r [2];
  delta_t               dp1_r [3];
  delta_t               dp2_r [3];
  delta_t               du1_r;
  delta_t               dv1_r;
  delta_t               du2_r;
  delta_t               dv2_r;

  acc_t                 acc_r;
  acc_t                 det_r;
  acc_t                 num_r [3];
  logic                 neg_r;
  logic [COORD_W-1:0]   tan_r [3];

  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                 out_user_r;

  logic [COORD_W-1:0]   in_f [5];
  logic                 in_acc;
  logic                 third;
  delta_t               op_a;
  delta_t               op_b;
  prod_t                prod;
  logic [2:0]           pidx;
  acc_t                 prod_s;
  acc_t                 prod_diff;
  logic                 div_start;
  logic [NUM_W-1:0]     dividend;
  logic [DEN_W-1:0]     divisor;
  div_res_t             div_res;
  logic [COORD_W-1:0]   limit;
  logic [COORD_W-1:0]   qmag;
  logic [COORD_W-1:0]   qres;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      in_f[i] = in_tdata[i*COORD_W +: COORD_W];
    end
  end

  // A corner index of three behaves like the third corner.
  assign third     = corner_r[1];
  assign in_tready = (state_r == ST_IDLE) && !(third && out_valid_r);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    unique case (cnt_r[2:0])
      3'd0:    begin op_a = du1_r;    op_b = dv2_r; end
      3'd1:    begin op_a = dv1_r;    op_b = du2_r; end
      3'd2:    begin op_a = dp1_r[0]; op_b = dv2_r; end
      3'd3:    begin op_a = dp2_r[0]; op_b = dv1_r; end
      3'd4:    begin op_a = dp1_r[1]; op_b = dv2_r; end
      3'd5:    begin op_a = dp2_r[1]; op_b = dv1_r; end
      3'd6:    begin op_a = dp1_r[2]; op_b = dv2_r; end
      default: begin op_a = dp2_r[2]; op_b = dv1_r; end
    endcase
  end

  ttuv_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod)
  );

  // The product issued in the previous cycle is consumed now: even products open
  // a sum, odd ones are subtracted from it.
  always_comb begin
    pidx      = 3'(cnt_r - 1'b1);
    prod_s    = prod.neg ? -ACC_W'(prod.mag) : ACC_W'(prod.mag);
    prod_diff = prod.neg ? acc_r + ACC_W'(prod.mag) : acc_r - ACC_W'(prod.mag);
  end

  assign div_start = (state_r == ST_DIV_START);
  assign dividend  = {mag_of(num_r[k_r]), {FRAC_BITS{1'b0}}};
  assign divisor   = mag_of(det_r);

  ttuv_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .res      (div_res)
  );

  always_comb begin
    limit = neg_r ? SAT_NEG : SAT_POS;
    qmag  = (div_res.ovf || div_res.quo > limit) ? limit : div_res.quo;
    qres  = neg_r ? -qmag : qmag;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && third) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt_r == MUL_CNT_W'(MUL_STEPS)) begin
          state_nxt = (det_r == '0) ? ST_IDLE : ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_res.done) begin
          state_nxt = (k_r == 2'd2) ? ST_IDLE : ST_DIV_START;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_r    <= 2'd0;
      cnt_r       <= '0;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        corner_r <= third ? 2'd0 : {1'b0, corner_r[0]} + 2'd1;
        cnt_r    <= '0;
      end
      if (state_r == ST_MUL) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MUL_CNT_W'(MUL_STEPS) && det_r == '0) begin
          out_valid_r <= 1'b1;
        end
        k_r <= 2'd0;
      end
      if (state_r == ST_DIV_WAIT && div_res.done) begin
        if (k_r == 2'd2) begin
          out_valid_r <= 1'b1;
        end
        k_r <= k_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (!third) begin
        if (corner_r[0]) begin
          for (int i = 0; i < 3; i++) p1_r[i] <= in_f[i];
          t1_r[0] <= in_f[3];
          t1_r[1] <= in_f[4];
        end else begin
          for (int i = 0; i < 3; i++) p0_r[i] <= in_f[i];
          t0_r[0] <= in_f[3];
          t0_r[1] <= in_f[4];
        end
      end else begin
        for (int i = 0; i < 3; i++) begin
          dp1_r[i] <= sx(p1_r[i]) - sx(p0_r[i]);
          dp2_r[i] <= sx(in_f[i]) - sx(p0_r[i]);
        end
        du1_r <= sx(t1_r[0]) - sx(t0_r[0]);
        dv1_r <= sx(t1_r[1]) - sx(t0_r[1]);
        du2_r <= sx(in_f[3]) - sx(t0_r[0]);
        dv2_r <= sx(in_f[4]) - sx(t0_r[1]);
      end
    end

    if (state_r == ST_MUL && cnt_r != '0) begin
      if (!pidx[0]) begin
        acc_r <= prod_s;
      end else begin
        unique case (pidx[2:1])
          2'd0:    det_r    <= prod_diff;
          2'd1:    num_r[0] <= prod_diff;
          2'd2:    num_r[1] <= prod_diff;
          default: num_r[2] <= prod_diff;
        endcase
      end
    end

    if (state_r == ST_MUL && cnt_r == MUL_CNT_W'(MUL_STEPS) && det_r == '0) begin
      out_data_r <= '0;
      out_user_r <= 1'b1;
    end

    if (div_start) begin
      neg_r <= num_r[k_r][ACC_W-1] ^ det_r[ACC_W-1];
    end

    if (state_r == ST_DIV_WAIT && div_res.done) begin
      tan_r[k_r] <= qres;
      if (k_r == 2'd2) begin
        out_data_r <= {qres, tan_r[1], tan_r[0]};
        out_user_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== rtl/ttuv_chk.sv =====
module ttuv_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [ttuv_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic                              out_tuser
);

  // A result word waiting at the output is not dropped.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // A degenerate triangle carries a zero tangent.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("degenerate word with nonzero tangent");

  // A result appears only after the sequencer has run, never in the cycle
  // right after a vertex was taken.
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready))
    else $error("result word raised right after a vertex");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid not cleared by reset");

endmodule

bind triangle_tangent_from_uv_core ttuv_chk u_ttuv_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/tb_top.sv =====
module tb_top;
  import ttuv_pkg::*;

  localparam int FRAC = 16;
  localparam int TRI_RANDOM = 176;
  localparam int HOLD_CYCLES = 400;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] CMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] CMIN = 32'h8000_0000;
  localparam logic signed [127:0] Q_MAX = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] Q_MIN = -128'sh8000_0000;

  // Packed so that the layout matches in_tdata: pos_x in the lowest word.
  typedef struct packed {
    logic [31:0]      tex_v;
    logic [31:0]      tex_u;
    logic [2:0][31:0] pos;
  } vertex_t;

  typedef struct packed {
    logic             degen;
    logic [2:0][31:0] axis;
  } tangent_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;

  vertex_t  vertex_q[$];
  tangent_t tangent_q[$];

  vertex_t  corner_held[2];
  int       corner_idx;
  logic     in_taken = 1'b0;
  int       sent_count = 0;
  int       tri_count = 0;
  int       vertex_total;
  int       fail_count = 0;
  int       words_checked = 0;
  int       degen_count = 0;
  int       sat_count = 0;
  int       hold_cnt = 0;
  logic     hold_done = 1'b0;
  int       tx_idle_pct;
  int       rx_idle_pct;
  tangent_t want;
  int       k;
  string    axis_name[3] = '{"x", "y", "z"};

  triangle_tangent_from_uv_core #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  function automatic logic signed [127:0] wide(input logic [31:0] v);
    return {{96{v[31]}}, v};
  endfunction

  // Exact quotient num * 2^FRAC / den, truncated toward zero, then saturated.
  function automatic logic [31:0] fixed_quotient(input logic signed [127:0] num,
                                                 input logic signed [127:0] den);
    logic signed [127:0] q;
    q = (num <<< FRAC) / den;
    if (q > Q_MAX) return SAT_POS;
    if (q < Q_MIN) return SAT_NEG;
    return q[31:0];
  endfunction

  function automatic tangent_t tangent_of(input vertex_t v0, input vertex_t v1,
                                          input vertex_t v2);
    tangent_t t;
    logic signed [127:0] du1, dv1, du2, dv2, det, num;
    du1 = wide(v1.tex_u) - wide(v0.tex_u);
    dv1 = wide(v1.tex_v) - wide(v0.tex_v);
    du2 = wide(v2.tex_u) - wide(v0.tex_u);
    dv2 = wide(v2.tex_v) - wide(v0.tex_v);
    det = du1 * dv2 - dv1 * du2;
    t.degen = (det == 0);
    for (int a = 0; a < 3; a++) begin
      if (t.degen) begin
        t.axis[a] = '0;
      end else begin
        num = (wide(v1.pos[a]) - wide(v0.pos[a])) * dv2
            - (wide(v2.pos[a]) - wide(v0.pos[a])) * dv1;
        t.axis[a] = fixed_quotient(num, det);
      end
    end
    return t;
  endfunction

  function automatic vertex_t vtx(input logic [31:0] x, input logic [31:0] y,
                                  input logic [31:0] z, input logic [31:0] u,
                                  input logic [31:0] v);
    vertex_t r;
    r.pos[0] = x;
    r.pos[1] = y;
    r.pos[2] = z;
    r.tex_u = u;
    r.tex_v = v;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return CMIN;
      1: return CMAX;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sender side: a word stays on the bus until taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (vertex_q.size() == 0 || $urandom_range(0, 99) < tx_idle_pct ||
          ((sent_count == 24 || sent_count == 300) && tangent_q.size() != 0)) begin
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata <= vertex_q.pop_front();
      end
    end
  end

  // Receiver side, with one long hold-off so that the core backs up.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && tri_count >= 40) begin
      out_tready <= 1'b0;
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always_comb begin
    if (sent_count < 183) begin
      tx_idle_pct = 29;
      rx_idle_pct = 62;
    end else if (sent_count < 366) begin
      tx_idle_pct = 62;
      rx_idle_pct = 29;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
      corner_idx = 0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        sent_count <= sent_count + 1;
        if (corner_idx < 2) begin
          corner_held[corner_idx] = vertex_t'(in_tdata);
          corner_idx = corner_idx + 1;
        end else begin
          corner_idx = 0;
          want = tangent_of(corner_held[0], corner_held[1], vertex_t'(in_tdata));
          tangent_q.push_back(want);
          tri_count <= tri_count + 1;
          if (want.degen) degen_count++;
          for (k = 0; k < 3; k++)
            if (!want.degen && (want.axis[k] == SAT_POS || want.axis[k] == SAT_NEG))
              sat_count++;
        end
      end
      if (out_tvalid && out_tready) begin
        if (tangent_q.size() == 0) begin
          $error("result word with nothing pending: tdata %h tuser %b",
                 out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = tangent_q.pop_front();
          words_checked++;
          for (k = 0; k < 3; k++)
            if (out_tdata[k*32 +: 32] !== want.axis[k]) begin
              $error("tangent_%s: expected %0d, got %0d", axis_name[k],
                     $signed(want.axis[k]), $signed(out_tdata[k*32 +: 32]));
              fail_count++;
            end
          if (out_tuser !== want.degen) begin
            $error("degenerate: expected %0b, got %0b", want.degen, out_tuser);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    vertex_t v0, v1, v2;
    int guard;

    // Unit tangent along x.
    vertex_q.push_back(vtx(0, 0, 0, 0, 0));
    vertex_q.push_back(vtx(ONE, 0, 0, ONE, 0));
    vertex_q.push_back(vtx(0, ONE, 0, 0, ONE));
    // All three texture coordinates equal.
    vertex_q.push_back(vtx(ONE, 2 * ONE, 3 * ONE, 5, 5));
    vertex_q.push_back(vtx(-ONE, 0, 7, 5, 5));
    vertex_q.push_back(vtx(CMAX, CMIN, 0, 5, 5));
    // Tiny determinant with full-swing positions: positive and negative saturation.
    vertex_q.push_back(vtx(CMIN, CMIN, CMIN, 0, 0));
    vertex_q.push_back(vtx(CMAX, CMAX, CMAX, 1, 0));
    vertex_q.push_back(vtx(0, 0, 0, 0, 1));
    vertex_q.push_back(vtx(CMAX, CMAX, CMAX, 0, 0));
    vertex_q.push_back(vtx(CMIN, CMIN, CMIN, 1, 0));
    vertex_q.push_back(vtx(0, 0, 0, 0, 1));
    // Extreme texture coordinates and mostly extreme positions.
    vertex_q.push_back(vtx(CMIN, CMAX, 0, CMIN, CMIN));
    vertex_q.push_back(vtx(CMAX, CMIN, ONE, CMAX, CMIN));
    vertex_q.push_back(vtx(CMIN, CMIN, CMAX, CMIN, CMAX));
    // Collinear texture coordinates.
    vertex_q.push_back(vtx(1, 2, 3, 0, 0));
    vertex_q.push_back(vtx(4, 5, 6, ONE, ONE));
    vertex_q.push_back(vtx(7, 8, 9, 2 * ONE, 2 * ONE));
    // Coincident positions with a negative determinant: zero, not degenerate.
    vertex_q.push_back(vtx(ONE, ONE, ONE, 0, 0));
    vertex_q.push_back(vtx(ONE, ONE, ONE, 0, ONE));
    vertex_q.push_back(vtx(ONE, ONE, ONE, ONE, 0));
    // Negative determinant with mixed-sign deltas.
    vertex_q.push_back(vtx(0, 0, 0, 0, 0));
    vertex_q.push_back(vtx(ONE, -ONE, 3 * ONE, 0, ONE));
    vertex_q.push_back(vtx(-2 * ONE, ONE, CMAX, ONE, 0));

    for (int t = 0; t < TRI_RANDOM; t++) begin
      v0 = vtx(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
      v1 = vtx(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
      v2 = vtx(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
      case ($urandom_range(0, 9))
        0: begin
          v1.tex_u = v0.tex_u;
          v1.tex_v = v0.tex_v;
        end
        1: begin
          v2.tex_u = v1.tex_u;
          v2.tex_v = v1.tex_v;
        end
        2: begin
          v1.pos = v0.pos;
          v2.pos = v0.pos;
        end
        3: begin
          // Unit determinant in raw steps, which usually drives saturation.
          v1.tex_u = v0.tex_u + 1;
          v1.tex_v = v0.tex_v;
          v2.tex_u = v0.tex_u;
          v2.tex_v = v0.tex_v + 1;
        end
        default: ;
      endcase
      vertex_q.push_back(v0);
      vertex_q.push_back(v1);
      vertex_q.push_back(v2);
    end
    vertex_total = vertex_q.size();

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (sent_count != vertex_total) @(negedge clk);
    guard = 0;
    while (tangent_q.size() != 0 && guard < 50000) begin
      @(negedge clk);
      guard++;
    end
    if (tangent_q.size() != 0) begin
      $error("%0d tangent words never arrived", tangent_q.size());
      fail_count++;
    end
    repeat (200) @(negedge clk);

    $display("Sent %0d vertices and checked %0d tangent words,", sent_count, words_checked);
    $display("%0d of them degenerate and %0d saturated components.", degen_count, sat_count);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #6000000;
    $display("simulation failed");
    $finish;
  end

endmodule
